[hdl/hbc_pkg.sv]
package hbc_pkg;

  // Datapath widths
  localparam int TIME_W  = 32;
  localparam int DEB_W   = 16;
  localparam int PULSE_W = 12;
  localparam int CODE_W  = 3;
  localparam int MASK_W  = 3;
  localparam int SPEED_W = 25;
  localparam int MECH_W  = SPEED_W - 1;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  // Motor constants
  localparam int RING_DEPTH   = 6;
  localparam int RING_IDX_W   = $clog2(RING_DEPTH);
  localparam int PWM_PERIOD   = 3200;
  localparam int BOOT_PERCENT = 95;
  localparam logic [PULSE_W-1:0] PWM_PERIOD_C   = PULSE_W'(PWM_PERIOD);
  localparam logic [PULSE_W-1:0] BOOT_COMPARE_C = PULSE_W'(PWM_PERIOD * BOOT_PERCENT / 100);
  localparam logic [PULSE_W-1:0] PULSE_MAX_C    = '1;
  localparam logic [MECH_W-1:0]  SPEED_MAX_C    = '1;

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Hall codes with all sensors equal carry no position
  localparam logic [CODE_W-1:0] HALL_ALL_LOW  = '0;
  localparam logic [CODE_W-1:0] HALL_ALL_HIGH = '1;

  // Step order for clockwise rotation
  localparam logic [CODE_W-1:0] MIRROR_TABLE [8] = '{
    3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
  };

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    FUNC_EDGE  = 2'd0,
    FUNC_PWM   = 2'd1,
    FUNC_START = 2'd2,
    FUNC_STOP  = 2'd3
  } func_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_CCW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_US   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_END      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US    = 3'd6;

  // Input tdata layout
  localparam int IN_NOW_LSB  = 0;
  localparam int IN_CODE_LSB = IN_NOW_LSB + TIME_W;
  localparam int IN_REQ_LSB  = IN_CODE_LSB + CODE_W;
  localparam int IN_BITS     = IN_REQ_LSB + PULSE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Result item, compare_u in the lowest bits
  typedef struct packed {
    logic                      timed_out;
    logic signed [SPEED_W-1:0] speed_rpm;
    logic [MASK_W-1:0]         low_enable;
    logic [MASK_W-1:0]         high_enable;
    logic [PULSE_W-1:0]        compare_w;
    logic [PULSE_W-1:0]        compare_v;
    logic [PULSE_W-1:0]        compare_u;
  } out_item_t;

  localparam int OUT_BITS    = $bits(out_item_t);
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

[hdl/hall_bldc_commutator_with_speed_top.sv]
// Six-step hall commutator with speed measurement. Each request on the slave
// stream is a timestamped event (hall edge, PWM request, start, stop) and gives
// exactly one result on the master stream: the three phase compares, the
// high- and low-side enables, the signed speed in rpm and a timeout flag.
// One request is in work at a time. A hall edge that commutates while running
// goes through decode, the subtract and add steps that update the running sum
// of the six-entry interval ring, the bit-serial restoring divider that forms
// speed_numerator / sum, saturate and sign, and the output register load, which
// waits until that register is free; it then returns to idle, where the next
// request is taken. Every other event (and a debounced, invalid or stopped edge)
// goes through decode, load and idle only. The result sits in an output register,
// so the next request may be taken while it waits.
// Configuration writes are taken at any clock but are meant for idle periods.
module hall_bldc_commutator_with_speed_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hbc_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Event stream
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  // tdata: now_us[31:0], hall_code[34:32], pwm_request[46:35], zero pad
  input  logic [hbc_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  // tuser: func[1:0]
  input  logic [1:0]                          s_tuser_i,
  // Result stream
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  // tdata: compare_u[11:0], compare_v[23:12], compare_w[35:24],
  //        high_enable[38:36], low_enable[41:39], speed_rpm[66:42],
  //        timed_out[67], zero pad
  output logic [hbc_pkg::OUT_TDATA_W-1:0]     m_tdata_o
);
  import hbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RSUB = 3'd2;
  localparam logic [2:0] S_RADD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SIGN = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  // Configuration
  logic                ccw_q;
  logic [DEB_W-1:0]    deb_q;
  logic [PULSE_W-1:0]  rstart_q, rstep_q, rend_q;
  logic [TIME_W-1:0]   num_q, tmo_q;

  // Control and motor state
  logic [2:0]                 state_q, state_d;
  logic                       running_q, running_d;
  logic [PULSE_W-1:0]         ramp_q, ramp_d;
  logic [TIME_W-1:0]          prev_q, prev_d, last_q, last_d;
  logic [TIME_W-1:0]          ring_q [RING_DEPTH];
  logic [TIME_W-1:0]          ring_d [RING_DEPTH];
  logic [RING_IDX_W-1:0]      idx_q, idx_d;
  logic [TIME_W-1:0]          sum_q, sum_d;
  logic [PULSE_W-1:0]         cmp_q [3];
  logic [PULSE_W-1:0]         cmp_d [3];
  logic [MASK_W-1:0]          hi_q, hi_d, lo_q, lo_d;
  logic signed [SPEED_W-1:0]  speed_q, speed_d;

  // Captured request and work registers
  func_e               func_q;
  logic [TIME_W-1:0]   now_q;
  logic [CODE_W-1:0]   code_q;
  logic [PULSE_W-1:0]  req_q;
  logic [TIME_W-1:0]   dt_q, dt_d;
  logic [TIME_W-1:0]   rem_q, rem_d, quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  // Combinational helpers
  logic                accept;
  logic [TIME_W-1:0]   dt;
  logic                code_ok;
  logic [PULSE_W-1:0]  ramp_lim;
  logic [PULSE_W:0]    ramp_sum;
  logic [PULSE_W-1:0]  ramp_inc;
  logic                drive_en;
  logic [PULSE_W-1:0]  duty, duty_c;
  logic [CODE_W-1:0]   step;
  logic [MASK_W-1:0]   pair_hi, pair_lo;
  logic [TIME_W:0]     div_try, div_diff;
  logic [MECH_W-1:0]   mech;
  logic [TIME_W-1:0]   age;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_q};

  // Store configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccw_q    <= 1'b0;
      deb_q    <= DEB_W'(50);
      rstart_q <= PULSE_W'(320);
      rstep_q  <= PULSE_W'(32);
      rend_q   <= PULSE_W'(480);
      num_q    <= TIME_W'(15000000);
      tmo_q    <= TIME_W'(2000000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIRECTION_CCW: ccw_q    <= cfg_wdata_i[0];
        REG_DEBOUNCE_US:   deb_q    <= cfg_wdata_i[DEB_W-1:0];
        REG_RAMP_START:    rstart_q <= cfg_wdata_i[PULSE_W-1:0];
        REG_RAMP_STEP:     rstep_q  <= cfg_wdata_i[PULSE_W-1:0];
        REG_RAMP_END:      rend_q   <= cfg_wdata_i[PULSE_W-1:0];
        REG_SPEED_NUM:     num_q    <= cfg_wdata_i[TIME_W-1:0];
        REG_TIMEOUT_US:    tmo_q    <= cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Look up the phase pair for the captured hall code
  always_comb begin
    step = ccw_q ? code_q : MIRROR_TABLE[code_q];
    unique case (step)
      3'd1:    begin pair_hi = 3'b100; pair_lo = 3'b010; end
      3'd2:    begin pair_hi = 3'b010; pair_lo = 3'b001; end
      3'd3:    begin pair_hi = 3'b100; pair_lo = 3'b001; end
      3'd4:    begin pair_hi = 3'b001; pair_lo = 3'b100; end
      3'd5:    begin pair_hi = 3'b001; pair_lo = 3'b010; end
      3'd6:    begin pair_hi = 3'b010; pair_lo = 3'b100; end
      default: begin pair_hi = '0;     pair_lo = '0;     end
    endcase
  end

  // Sequence a request: decode, ring update and divide (commutating edges), output
  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    ramp_d      = ramp_q;
    prev_d      = prev_q;
    last_d      = last_q;
    ring_d      = ring_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    cmp_d       = cmp_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    speed_d     = speed_q;
    dt_d        = dt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    drive_en    = 1'b0;
    duty        = ramp_q;

    dt       = now_q - prev_q;
    code_ok  = (code_q != HALL_ALL_LOW) && (code_q != HALL_ALL_HIGH);
    ramp_lim = (rend_q > PWM_PERIOD_C) ? PWM_PERIOD_C : rend_q;
    ramp_sum = {1'b0, ramp_q} + {1'b0, rstep_q};
    ramp_inc = ramp_sum[PULSE_W] ? PULSE_MAX_C : ramp_sum[PULSE_W-1:0];
    div_try  = {rem_q, quo_q[TIME_W-1]};
    div_diff = div_try - {1'b0, sum_q};
    mech     = (|quo_q[TIME_W-1:MECH_W]) ? SPEED_MAX_C : quo_q[MECH_W-1:0];
    age      = now_q - last_q;

    // Drop the result once taken
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_PUSH;
        unique case (func_q)
          FUNC_EDGE: begin
            if (dt >= TIME_W'(deb_q)) begin
              prev_d = now_q;
              last_d = now_q;
              if (code_ok) begin
                if (!running_q) begin
                  speed_d = '0;
                end else begin
                  if (ramp_q < ramp_lim) begin
                    ramp_d = ramp_inc;
                  end
                  drive_en = 1'b1;
                  duty     = ramp_d;
                  dt_d     = dt;
                  state_d  = S_RSUB;
                end
              end
            end
          end
          FUNC_PWM: begin
            if (running_q && (ramp_q >= ramp_lim)) begin
              drive_en = code_ok;
              duty     = req_q;
              if (req_q > ramp_q) begin
                ramp_d = req_q;
              end
            end
          end
          FUNC_START: begin
            ramp_d    = rstart_q;
            running_d = 1'b1;
            last_d    = now_q;
            drive_en  = code_ok;
            duty      = rstart_q;
          end
          FUNC_STOP: begin
            running_d = 1'b0;
            ramp_d    = rstart_q;
            for (int p = 0; p < 3; p++) begin
              cmp_d[p] = BOOT_COMPARE_C;
            end
            hi_d    = '0;
            lo_d    = '1;
            speed_d = '0;
          end
        endcase
      end
      S_RSUB: begin
        // Remove the oldest interval from the running sum
        sum_d   = sum_q - ring_q[idx_q];
        state_d = S_RADD;
      end
      S_RADD: begin
        // Add the new interval, advance the ring and arm the divider
        sum_d         = sum_q + dt_q;
        ring_d[idx_q] = dt_q;
        idx_d         = (idx_q == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : idx_q + 1'b1;
        quo_d         = num_q;
        rem_d         = '0;
        cnt_d         = '0;
        state_d       = S_DIV;
      end
      S_DIV: begin
        // One restoring division step per cycle
        if (!div_diff[TIME_W]) begin
          rem_d = div_diff[TIME_W-1:0];
          quo_d = {quo_q[TIME_W-2:0], 1'b1};
        end else begin
          rem_d = div_try[TIME_W-1:0];
          quo_d = {quo_q[TIME_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        // Saturate the quotient and apply the direction sign
        if (sum_q == '0) begin
          speed_d = '0;
        end else if (ccw_q) begin
          speed_d = -$signed({1'b0, mech});
        end else begin
          speed_d = $signed({1'b0, mech});
        end
        state_d = S_PUSH;
      end
      S_PUSH: begin
        // Hold until the output register is free
        if (!out_valid_q || m_tready_i) begin
          out_valid_d       = 1'b1;
          out_d.compare_u   = cmp_q[0];
          out_d.compare_v   = cmp_q[1];
          out_d.compare_w   = cmp_q[2];
          out_d.high_enable = hi_q;
          out_d.low_enable  = lo_q;
          out_d.speed_rpm   = speed_q;
          out_d.timed_out   = (age > tmo_q);
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Commutate: clear all enables, then drive the selected pair
    duty_c = (duty > PWM_PERIOD_C) ? PWM_PERIOD_C : duty;
    if (drive_en) begin
      hi_d = pair_hi;
      lo_d = pair_lo;
      for (int p = 0; p < 3; p++) begin
        if (pair_hi[p]) begin
          cmp_d[p] = duty_c;
        end else if (pair_lo[p]) begin
          cmp_d[p] = '0;
        end
      end
    end
  end

  // Control and motor state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      ramp_q      <= PULSE_W'(320);
      prev_q      <= '0;
      last_q      <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      idx_q       <= '0;
      sum_q       <= '0;
      for (int p = 0; p < 3; p++) begin
        cmp_q[p] <= BOOT_COMPARE_C;
      end
      hi_q        <= '0;
      lo_q        <= '1;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      ramp_q      <= ramp_d;
      prev_q      <= prev_d;
      last_q      <= last_d;
      ring_q      <= ring_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      cmp_q       <= cmp_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(s_tuser_i);
      now_q  <= s_tdata_i[IN_NOW_LSB +: TIME_W];
      code_q <= s_tdata_i[IN_CODE_LSB +: CODE_W];
      req_q  <= s_tdata_i[IN_REQ_LSB +: PULSE_W];
    end
    dt_q  <= dt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

endmodule

[hdl/hbc_checker.sv]
module hbc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_tvalid_i,
  input logic                             s_tready_o,
  input logic                             m_tvalid_o,
  input logic                             m_tready_i,
  input logic [hbc_pkg::OUT_TDATA_W-1:0]  m_tdata_o
);
  import hbc_pkg::*;

  out_item_t item;
  assign item = out_item_t'(m_tdata_o[OUT_BITS-1:0]);

  // One request in work: no second request right after an accept
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request accepted while another is in work");

  // Never drive both switches of one leg, at most one high side on
  a_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ((item.high_enable & item.low_enable) == '0)
                   && ($countones(item.high_enable) <= 1))
    else $error("illegal enable pattern");

  // Compares stay within the PWM period
  a_compare_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (item.compare_u <= PWM_PERIOD_C)
                   && (item.compare_v <= PWM_PERIOD_C)
                   && (item.compare_w <= PWM_PERIOD_C))
    else $error("compare beyond PWM period");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled result changed");

endmodule

bind hall_bldc_commutator_with_speed_top hbc_checker u_hbc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import hbc_pkg::*;

  localparam int PERIOD_COUNTS = 3200;
  localparam int BOOT_DUTY     = PERIOD_COUNTS * 95 / 100;
  localparam int RING_LEN      = 6;
  localparam int PHASE_EVENTS  = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 45;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;

  // Parked drive: bootstrap compares, all low sides on, no speed
  localparam out_item_t PARKED =
    {1'b0, 25'd0, 3'b111, 3'b000, 12'd3040, 12'd3040, 12'd3040};
  localparam out_item_t PARKED_LATE =
    {1'b1, 25'd0, 3'b111, 3'b000, 12'd3040, 12'd3040, 12'd3040};

  typedef struct packed {
    func_e       f;
    logic [31:0] now;
    logic [2:0]  code;
    logic [11:0] req;
    logic        fixed;
    out_item_t   want;
  } plan_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Shared between the request side, the result side and the watchdog
  logic      steady_run = 1'b0;
  logic      hold_off_req = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        stall_cycles = 0;
  int        events_sent = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        settings_used = 1;
  out_item_t pending_drive_q [$];

  // Shadow copy of the commutator: registers
  logic        hm_dir_ccw;
  logic [15:0] hm_debounce;
  logic [11:0] hm_ramp_start;
  logic [11:0] hm_ramp_step;
  logic [11:0] hm_ramp_end;
  logic [31:0] hm_speed_num;
  logic [31:0] hm_timeout;
  // Shadow copy of the commutator: state
  logic        hm_running;
  logic [11:0] hm_ramp;
  logic [31:0] hm_prev_edge;
  logic [31:0] hm_last_edge;
  logic [31:0] hm_ring [RING_LEN];
  int          hm_ring_pos;
  logic [11:0] hm_cmp [3];
  logic [2:0]  hm_high;
  logic [2:0]  hm_low;
  logic [24:0] hm_speed;

  // Stimulus timeline for the random part
  logic [31:0] stamp_us;
  logic [2:0]  rotor_code;

  hall_bldc_commutator_with_speed_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic hall_valid(logic [2:0] code);
    return code != HALL_ALL_LOW && code != HALL_ALL_HIGH;
  endfunction

  function automatic logic [11:0] ramp_ceiling();
    return (hm_ramp_end > PERIOD_COUNTS) ? 12'(PERIOD_COUNTS) : hm_ramp_end;
  endfunction

  // Park the bridge: bootstrap compares, low sides on, stop the motor
  function automatic void park_model();
    hm_running = 1'b0;
    hm_ramp    = hm_ramp_start;
    for (int i = 0; i < 3; i++) hm_cmp[i] = 12'(BOOT_DUTY);
    hm_high  = 3'b000;
    hm_low   = 3'b111;
    hm_speed = '0;
  endfunction

  // Drive one phase pair: high side gets the clamped duty, low side 0
  function automatic void apply_pair(logic [2:0] code, logic [11:0] duty);
    logic [2:0] pos;
    int hi;
    int lo;
    if (duty > PERIOD_COUNTS) duty = 12'(PERIOD_COUNTS);
    pos = hm_dir_ccw ? code : 3'(7 - code);
    case (pos)
      3'd1: begin hi = 2; lo = 1; end
      3'd2: begin hi = 1; lo = 0; end
      3'd3: begin hi = 2; lo = 0; end
      3'd4: begin hi = 0; lo = 2; end
      3'd5: begin hi = 0; lo = 1; end
      default: begin hi = 1; lo = 2; end
    endcase
    hm_cmp[hi] = duty;
    hm_cmp[lo] = '0;
    hm_high = 3'(1 << hi);
    hm_low  = 3'(1 << lo);
  endfunction

  // Advance the shadow commutator by one event and return its drive outputs
  function automatic out_item_t step_commutator_model(func_e f, logic [31:0] now,
                                                      logic [2:0] code, logic [11:0] req);
    logic [31:0] dt;
    logic [31:0] sum;
    logic [31:0] mech;
    logic [12:0] raised;
    out_item_t   r;
    dt = now - hm_prev_edge;
    case (f)
      FUNC_EDGE: begin
        if (dt >= hm_debounce) begin
          hm_prev_edge = now;
          hm_last_edge = now;
          if (hall_valid(code)) begin
            if (!hm_running) begin
              hm_speed = '0;
            end else begin
              // soft start: raise the duty, saturate at the counter width
              if (hm_ramp < ramp_ceiling()) begin
                raised  = {1'b0, hm_ramp} + {1'b0, hm_ramp_step};
                hm_ramp = raised[12] ? 12'hFFF : raised[11:0];
              end
              apply_pair(code, hm_ramp);
              hm_ring[hm_ring_pos] = dt;
              hm_ring_pos = (hm_ring_pos + 1) % RING_LEN;
              sum = '0;
              for (int i = 0; i < RING_LEN; i++) sum = sum + hm_ring[i];
              mech = (sum != 0) ? hm_speed_num / sum : 32'd0;
              if (mech > 32'h00FF_FFFF) mech = 32'h00FF_FFFF;
              hm_speed = 25'(hm_dir_ccw ? (32'd0 - mech) : mech);
            end
          end
        end
      end
      FUNC_PWM: begin
        if (hm_running && hm_ramp >= ramp_ceiling()) begin
          if (hall_valid(code)) apply_pair(code, req);
          if (req > hm_ramp) hm_ramp = req;
        end
      end
      FUNC_START: begin
        hm_ramp      = hm_ramp_start;
        hm_running   = 1'b1;
        hm_last_edge = now;
        if (hall_valid(code)) apply_pair(code, hm_ramp);
      end
      default: park_model();
    endcase
    r.compare_u   = hm_cmp[0];
    r.compare_v   = hm_cmp[1];
    r.compare_w   = hm_cmp[2];
    r.high_enable = hm_high;
    r.low_enable  = hm_low;
    r.speed_rpm   = hm_speed;
    r.timed_out   = (now - hm_last_edge) > hm_timeout;
    return r;
  endfunction

  // Write one register and mirror it into the shadow copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DIRECTION_CCW: hm_dir_ccw    = val[0];
      REG_DEBOUNCE_US:   hm_debounce   = val[15:0];
      REG_RAMP_START:    hm_ramp_start = val[11:0];
      REG_RAMP_STEP:     hm_ramp_step  = val[11:0];
      REG_RAMP_END:      hm_ramp_end   = val[11:0];
      REG_SPEED_NUM:     hm_speed_num  = val;
      REG_TIMEOUT_US:    hm_timeout    = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic dir, logic [15:0] deb, logic [11:0] ramp_lo,
                               logic [11:0] ramp_inc, logic [11:0] ramp_top,
                               logic [31:0] num, logic [31:0] limit_us);
    write_reg(REG_DIRECTION_CCW, 32'(dir));
    write_reg(REG_DEBOUNCE_US, 32'(deb));
    write_reg(REG_RAMP_START, 32'(ramp_lo));
    write_reg(REG_RAMP_STEP, 32'(ramp_inc));
    write_reg(REG_RAMP_END, 32'(ramp_top));
    write_reg(REG_SPEED_NUM, num);
    write_reg(REG_TIMEOUT_US, limit_us);
    settings_used++;
  endtask

  // Offer one request, wait for its handshake, then record the drive it causes
  task automatic offer_event(func_e f, logic [31:0] now, logic [2:0] code,
                             logic [11:0] req, logic fixed, out_item_t want);
    out_item_t predicted;
    while (!steady_run && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({req, code, now});
    s_tuser  <= f;
    do @(posedge clk_i); while (!s_tready);
    predicted = step_commutator_model(f, now, code, req);
    pending_drive_q.push_back(fixed ? want : predicted);
    events_sent++;
  endtask

  // Mostly a running motor: start, rotating edges, duty requests, rare stops
  task automatic send_random_event();
    int          pick;
    logic [31:0] gap;
    logic [31:0] now;
    func_e       f;
    logic [2:0]  code;
    logic [11:0] req;
    pick = $urandom_range(99);
    req  = 12'($urandom_range(4095));
    if (pick < 8) begin
      // noise: any request, any time, any code
      f    = func_e'($urandom_range(3));
      now  = $urandom();
      code = 3'($urandom_range(7));
    end else if (!hm_running || pick < 10) begin
      f    = (pick < 10 && hm_running) ? FUNC_STOP : FUNC_START;
      rotor_code = 3'(rotor_code % 6 + 1);
      code = rotor_code;
      stamp_us = stamp_us + $urandom_range(0, 300);
      now  = stamp_us;
    end else if (pick < 25) begin
      f    = FUNC_PWM;
      code = (pick < 13) ? 3'($urandom_range(7)) : rotor_code;
      stamp_us = stamp_us + $urandom_range(0, 200);
      now  = stamp_us;
    end else begin
      f = FUNC_EDGE;
      pick = $urandom_range(99);
      if (pick < 80)      gap = 32'(hm_debounce) + $urandom_range(0, 4000);
      else if (pick < 90) gap = $urandom_range(0, 32'(hm_debounce));
      else if (pick < 95) gap = $urandom_range(0, 32'h7FFF_FFFF);
      else                gap = $urandom();
      stamp_us = stamp_us + gap;
      now = stamp_us;
      if ($urandom_range(99) < 5) begin
        code = $urandom_range(1) ? HALL_ALL_HIGH : HALL_ALL_LOW;
      end else begin
        rotor_code = 3'(rotor_code % 6 + 1);
        code = rotor_code;
      end
    end
    offer_event(f, now, code, req, 1'b0, '0);
  endtask

  // Result side: random stalls, one long hold-off, steady stretch on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (steady_run) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 27);
    end
  end

  // Check each result against the oldest recorded drive
  always @(posedge clk_i) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      results_seen++;
      if (pending_drive_q.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("result %0d arrived with nothing outstanding", results_seen);
        mismatches++;
      end else begin
        want = pending_drive_q.pop_front();
        if (got.compare_u !== want.compare_u || got.compare_v !== want.compare_v ||
            got.compare_w !== want.compare_w || got.high_enable !== want.high_enable ||
            got.low_enable !== want.low_enable || got.speed_rpm !== want.speed_rpm ||
            got.timed_out !== want.timed_out) begin
          if (mismatches < REPORT_MAX) begin
            $display("result %0d differs at %0t", results_seen, $realtime);
            $display("  want u %0d v %0d w %0d hi %b lo %b rpm %0d tmo %b",
                     want.compare_u, want.compare_v, want.compare_w, want.high_enable,
                     want.low_enable, want.speed_rpm, want.timed_out);
            $display("  got  u %0d v %0d w %0d hi %b lo %b rpm %0d tmo %b",
                     got.compare_u, got.compare_v, got.compare_w, got.high_enable,
                     got.low_enable, got.speed_rpm, got.timed_out);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    plan_row_t row;

    // Shadow copy starts from reset values
    hm_dir_ccw    = 1'b0;
    hm_debounce   = 16'd50;
    hm_ramp_start = 12'd320;
    hm_ramp_step  = 12'd32;
    hm_ramp_end   = 12'd480;
    hm_speed_num  = 32'd15000000;
    hm_timeout    = 32'd2000000;
    hm_prev_edge  = '0;
    hm_last_edge  = '0;
    hm_ring_pos   = 0;
    for (int i = 0; i < RING_LEN; i++) hm_ring[i] = '0;
    park_model();
    rotor_code = 3'd1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stopped motor first: parked drive no matter what comes in
    plan.push_back({FUNC_STOP,  32'd0,          3'd0, 12'd0,    1'b1, PARKED});
    // too close to the last edge
    plan.push_back({FUNC_EDGE,  32'd10,         3'd3, 12'd0,    1'b1, PARKED});
    // duty request while stopped
    plan.push_back({FUNC_PWM,   32'd20,         3'd1, 12'd2000, 1'b1, PARKED});
    // hall codes with all sensors equal
    plan.push_back({FUNC_EDGE,  32'd100,        3'd0, 12'd0,    1'b1, PARKED});
    plan.push_back({FUNC_EDGE,  32'd200,        3'd7, 12'd0,    1'b1, PARKED});
    // valid edges while stopped only take the time
    plan.push_back({FUNC_EDGE,  32'd300,        3'd5, 12'd0,    1'b1, PARKED});
    plan.push_back({FUNC_EDGE,  32'hFFFF_FFFF,  3'd2, 12'd0,    1'b1, PARKED});
    // half the time range since the last edge: stale
    plan.push_back({FUNC_PWM,   32'h7FFF_FFFF,  3'd4, 12'hFFF,  1'b1, PARKED_LATE});
    // start, then soft start over the timestamp wrap
    plan.push_back({FUNC_START, 32'd1000,       3'd1, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd2000,       3'd3, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd3000,       3'd2, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd3020,       3'd6, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd4000,       3'd6, 12'd0,    1'b0, PARKED});
    // request during soft start is dropped
    plan.push_back({FUNC_PWM,   32'd4100,       3'd4, 12'd4000, 1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd5000,       3'd4, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd6000,       3'd5, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd7000,       3'd7, 12'd0,    1'b0, PARKED});
    // full-scale request: duty clamps, ramp takes the request
    plan.push_back({FUNC_PWM,   32'd7100,       3'd1, 12'hFFF,  1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd8000,       3'd1, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_PWM,   32'd8100,       3'd0, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_PWM,   32'd8200,       3'd3, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_START, 32'd9000,       3'd0, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_EDGE,  32'd10000,      3'd2, 12'd0,    1'b0, PARKED});
    plan.push_back({FUNC_STOP,  32'd11000,      3'd6, 12'd0,    1'b1, PARKED});
    foreach (plan[i]) begin
      row = plan[i];
      offer_event(row.f, row.now, row.code, row.req, row.fixed, row.want);
    end
    s_tvalid <= 1'b0;
    stamp_us = 32'd11000;

    // Random phases, each under its own register setting
    for (int phase = 1; phase <= 6; phase++) begin
      while (pending_drive_q.size() != 0) @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      case (phase)
        1: load_settings(1'b1, 16'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0);
        2: load_settings(1'b0, 16'hFFFF, 12'd3100, 12'd3200, 12'd3200,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: load_settings(1'b1, 16'd50, 12'd320, 12'd32, 12'd480,
                         32'd15000000, 32'd2000000);
        default: load_settings(1'($urandom_range(1)), 16'($urandom_range(0, 1000)),
                               12'($urandom_range(0, 3200)), 12'($urandom_range(0, 600)),
                               12'($urandom_range(0, 3200)), $urandom(),
                               $urandom_range(0, 200000));
      endcase
      if (phase == 3) steady_run <= 1'b1;
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        if (phase == 3 && n == 30) hold_off_req <= 1'b1;
        send_random_event();
      end
      s_tvalid   <= 1'b0;
      steady_run <= 1'b0;
    end

    // Drain, then let the pipeline settle
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d events (edges, duty requests, starts, stops) under %0d settings",
             events_sent, settings_used);
    $display("%0d drive results checked, %0d in error", results_seen, mismatches);
    if (mismatches == 0 && pending_drive_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[hall_bldc_commutator_with_speed_top.f]
hdl/hbc_pkg.sv
hdl/hall_bldc_commutator_with_speed_top.sv
hdl/hbc_checker.sv
bench/tb_top.sv
